[design/tsrl_pkg.sv]
// shared types, constants and codes for the schedule region lookup block
`timescale 1ns / 1ps

package tsrl_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

   localparam int EPOCH_W   = 40;
   localparam int OFFSET_W  = 32;
   localparam int WINDOW_W  = 16;
   localparam int TIME_W    = 41;
   localparam int CNT_REG_W = 7;
   localparam int ENTRY_W   = OFFSET_W + 2;

   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 128;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 40;

   // request word layout
   localparam int REQ_IDX_LSB    = 0;
   localparam int REQ_OFS_LSB    = 6;
   localparam int REQ_ON_BIT     = 38;
   localparam int REQ_RESUME_BIT = 39;
   localparam int REQ_NOW_LSB    = 40;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EPOCH  = 2'd0,
      CSR_COUNT  = 2'd1,
      CSR_WINDOW = 2'd2
   } csr_index_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic              load_query;
      logic              prep;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              proc;
      logic              load_out;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count_lim;
   } status_type;

endpackage

[design/tsrl_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tsrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tsrl_ctrl.sv]
// sequencer for table writes and query scans
`timescale 1ns / 1ps

module tsrl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_op,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tsrl_pkg::status_type   status,
   output tsrl_pkg::cmd_type      cmd
);

   tsrl_pkg::state_type state_ff, state_in;
   logic [tsrl_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic proc_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic more;
   logic out_free;

   assign more     = idx_ff < status.count_lim;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsrl_pkg::ST_IDLE: begin
            if (req_tvalid && req_op == tsrl_pkg::OP_QUERY) begin
               state_in = tsrl_pkg::ST_PREP;
            end
         end
         tsrl_pkg::ST_PREP: begin
            state_in = tsrl_pkg::ST_SCAN;
         end
         tsrl_pkg::ST_SCAN: begin
            if (!more) begin
               state_in = tsrl_pkg::ST_FINISH;
            end
         end
         tsrl_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = tsrl_pkg::ST_IDLE;
            end
         end
         default: state_in = tsrl_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready     = 1'b0;
      cmd.wr_en      = 1'b0;
      cmd.load_query = 1'b0;
      cmd.prep       = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.rd_addr    = idx_ff[tsrl_pkg::ADDR_W-1:0];
      cmd.proc       = proc_ff;
      cmd.load_out   = 1'b0;
      unique case (state_ff)
         tsrl_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.wr_en      = req_tvalid && req_op == tsrl_pkg::OP_WRITE;
            cmd.load_query = req_tvalid && req_op == tsrl_pkg::OP_QUERY;
         end
         tsrl_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
         end
         tsrl_pkg::ST_SCAN: begin
            cmd.rd_en = more;
         end
         tsrl_pkg::ST_FINISH: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (state_ff == tsrl_pkg::ST_PREP) begin
         idx_in = '0;
      end else if (cmd.rd_en) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsrl_pkg::ST_IDLE;
         idx_ff       <= '0;
         proc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         proc_ff      <= cmd.rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[design/tsrl_dpath.sv]
// config registers, entry table, scan accumulators and result register
`timescale 1ns / 1ps

module tsrl_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [tsrl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tsrl_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic [tsrl_pkg::REQ_DATA_W-1:0]   req_data,
   input  tsrl_pkg::cmd_type                 cmd,
   output tsrl_pkg::status_type              status,
   output logic [tsrl_pkg::RSP_DATA_W-1:0]   rsp_data
);

   logic [tsrl_pkg::EPOCH_W-1:0]   epoch_ff;
   logic [tsrl_pkg::CNT_REG_W-1:0] count_ff;
   logic [tsrl_pkg::WINDOW_W-1:0]  window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff  <= '0;
         count_ff  <= '0;
         window_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            tsrl_pkg::CSR_EPOCH:  epoch_ff  <= csr_data;
            tsrl_pkg::CSR_COUNT:  count_ff  <= csr_data[tsrl_pkg::CNT_REG_W-1:0];
            tsrl_pkg::CSR_WINDOW: window_ff <= csr_data[tsrl_pkg::WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   assign status.count_lim =
      (count_ff > tsrl_pkg::CNT_REG_W'(tsrl_pkg::MAX_ENTRIES))
         ? tsrl_pkg::COUNT_W'(tsrl_pkg::MAX_ENTRIES)
         : tsrl_pkg::COUNT_W'(count_ff);

   // request fields
   logic [tsrl_pkg::ADDR_W-1:0]   req_idx;
   logic [tsrl_pkg::OFFSET_W-1:0] req_ofs;
   logic                          req_on;
   logic                          req_resume;
   logic [tsrl_pkg::EPOCH_W-1:0]  req_now;

   assign req_idx    = req_data[tsrl_pkg::REQ_IDX_LSB +: tsrl_pkg::ADDR_W];
   assign req_ofs    = req_data[tsrl_pkg::REQ_OFS_LSB +: tsrl_pkg::OFFSET_W];
   assign req_on     = req_data[tsrl_pkg::REQ_ON_BIT];
   assign req_resume = req_data[tsrl_pkg::REQ_RESUME_BIT];
   assign req_now    = req_data[tsrl_pkg::REQ_NOW_LSB +: tsrl_pkg::EPOCH_W];

   // entry table: {resume, on, offset}
   logic [tsrl_pkg::ENTRY_W-1:0] rd_entry;

   tsrl_ram #(
      .WIDTH (tsrl_pkg::ENTRY_W),
      .DEPTH (tsrl_pkg::MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (req_idx),
      .wr_data ({req_resume, req_on, req_ofs}),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_entry)
   );

   // query setup: elapsed, then elapsed minus window for the window test
   logic [tsrl_pkg::EPOCH_W-1:0] elapsed_ff;
   logic [tsrl_pkg::EPOCH_W-1:0] win_edge_ff;
   logic                         win_always_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         elapsed_ff <= (req_now > epoch_ff) ? (req_now - epoch_ff) : '0;
      end
      if (cmd.prep) begin
         win_always_ff <= elapsed_ff < tsrl_pkg::EPOCH_W'(window_ff);
         win_edge_ff   <= elapsed_ff - tsrl_pkg::EPOCH_W'(window_ff);
      end
   end

   // per-entry evaluation
   logic [tsrl_pkg::OFFSET_W-1:0] ent_ofs;
   logic                          ent_on;
   logic                          ent_resume;
   logic [tsrl_pkg::EPOCH_W-1:0]  ent_ofs_x;
   logic [tsrl_pkg::TIME_W-1:0]   ent_abs;
   logic                          ent_earlier;
   logic                          ent_in_win;

   assign ent_ofs     = rd_entry[tsrl_pkg::OFFSET_W-1:0];
   assign ent_on      = rd_entry[tsrl_pkg::OFFSET_W];
   assign ent_resume  = rd_entry[tsrl_pkg::OFFSET_W+1];
   assign ent_ofs_x   = tsrl_pkg::EPOCH_W'(ent_ofs);
   assign ent_abs     = tsrl_pkg::TIME_W'(ent_ofs) + tsrl_pkg::TIME_W'(epoch_ff);
   assign ent_earlier = ent_ofs_x < elapsed_ff;
   // elapsed < ofs + window, rewritten so no sum is needed per entry
   assign ent_in_win  = win_always_ff || (ent_ofs_x > win_edge_ff);

   logic                        cur_on_ff, cur_res_ff, win_ff;
   logic [tsrl_pkg::TIME_W-1:0] start_ff;
   logic                        on_found_ff, off_found_ff;
   logic [tsrl_pkg::TIME_W-1:0] on_time_ff, off_time_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         cur_on_ff    <= 1'b0;
         cur_res_ff   <= 1'b0;
         win_ff       <= 1'b0;
         start_ff     <= '0;
         on_found_ff  <= 1'b0;
         on_time_ff   <= '0;
         off_found_ff <= 1'b0;
         off_time_ff  <= '0;
      end else if (cmd.proc) begin
         if (ent_earlier) begin
            cur_on_ff  <= ent_on;
            cur_res_ff <= ent_resume;
            start_ff   <= ent_abs;
            if (ent_in_win) begin
               win_ff <= 1'b1;
            end
         end else if (ent_on) begin
            if (!on_found_ff) begin
               on_found_ff <= 1'b1;
               on_time_ff  <= ent_abs;
            end
         end else begin
            if (!off_found_ff) begin
               off_found_ff <= 1'b1;
               off_time_ff  <= ent_abs;
            end
         end
      end
   end

   logic [tsrl_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {off_time_ff, off_found_ff, on_time_ff, on_found_ff,
                         start_ff, win_ff, cur_res_ff, cur_on_ff};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

[design/time_schedule_region_lookup.sv]
// top level of the schedule region lookup block
//
// Input words arrive on req_*. req_tuser selects the operation: a write word
// stores one schedule entry (index, offset, on flag, resume flag) into the
// 64-entry table and answers nothing; a query word carries the current time
// and answers one word on rsp_* with the current region and the next on and
// off times. Registers (epoch, entry count, window length) are written on
// csr_*; the user must write them only while the block is idle, which the
// block itself leaves unchecked; csr_ready is always high. A query scans
// the table one entry per cycle through the single read port of the entry
// table, over entry_count entries (capped at 64), and req_tready stays low
// until its result is loaded for output. A result waiting for
// rsp_tready sits in an output register; the next write or query is taken
// meanwhile, and a following query only holds in its last step until the
// waiting word is taken.
// Reset clears the registers and the handshake state; table contents are
// undefined until written, and a query must only scan written entries.
`timescale 1ns / 1ps

module time_schedule_region_lookup (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // entry_index, entry_offset, entry_turns_on, entry_may_resume, now_seconds
   input  logic [tsrl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // current_on, current_resume, in_window, window_start, next_on_found,
   // next_on_time, next_off_found, next_off_time
   output logic [tsrl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tsrl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tsrl_pkg::CSR_DATA_W-1:0]    csr_data
);

   tsrl_pkg::cmd_type    cmd;
   tsrl_pkg::status_type status;

   assign csr_ready = 1'b1;

   tsrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tsrl_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule

[dv/testbench.sv]
// self-checking testbench for the schedule region lookup block
`timescale 1ns / 1ps

module testbench;

   // register index the block does not implement, written once to show it is ignored
   localparam logic [tsrl_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic                          op;
      logic [tsrl_pkg::ADDR_W-1:0]   idx;
      logic [tsrl_pkg::OFFSET_W-1:0] ofs;
      logic                          turns_on;
      logic                          may_resume;
      logic [tsrl_pkg::EPOCH_W-1:0]  now;
   } sched_word_type;

   // first member sits in the top bits, so current_on lands in bit 0
   typedef struct packed {
      logic [tsrl_pkg::TIME_W-1:0] next_off_time;
      logic                        next_off_found;
      logic [tsrl_pkg::TIME_W-1:0] next_on_time;
      logic                        next_on_found;
      logic [tsrl_pkg::TIME_W-1:0] window_start;
      logic                        in_window;
      logic                        current_resume;
      logic                        current_on;
   } region_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [tsrl_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [tsrl_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [tsrl_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [tsrl_pkg::CSR_DATA_W-1:0]   csr_data = '0;

   time_schedule_region_lookup dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state
   logic [tsrl_pkg::EPOCH_W-1:0]   epoch_cfg = '0;
   logic [tsrl_pkg::CNT_REG_W-1:0] count_cfg = '0;
   logic [tsrl_pkg::WINDOW_W-1:0]  window_cfg = '0;
   logic [tsrl_pkg::OFFSET_W-1:0]  ofs_tab[tsrl_pkg::MAX_ENTRIES];
   logic                           on_tab[tsrl_pkg::MAX_ENTRIES];
   logic                           resume_tab[tsrl_pkg::MAX_ENTRIES];

   sched_word_type stim_words[$];
   region_type     pending_regions[$];
   sched_word_type offered;
   region_type     got_region;
   region_type     want_region;
   bit             gen_written[tsrl_pkg::MAX_ENTRIES];
   int             send_idle_pct = 23;
   int             recv_idle_pct = 77;
   bit             rsp_hold = 1'b0;
   int             errors = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [tsrl_pkg::EPOCH_W-1:0] rand40();
      return tsrl_pkg::EPOCH_W'({$urandom, $urandom});
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic region_type lookup_region(logic [tsrl_pkg::EPOCH_W-1:0] now);
      region_type                  r;
      logic [tsrl_pkg::TIME_W-1:0] elapsed;
      logic [tsrl_pkg::TIME_W-1:0] ofs_w;
      logic [tsrl_pkg::TIME_W-1:0] abs_t;
      int                          lim;
      r = '0;
      elapsed = (now > epoch_cfg) ? {1'b0, now - epoch_cfg} : '0;
      lim = (count_cfg > tsrl_pkg::MAX_ENTRIES) ? tsrl_pkg::MAX_ENTRIES : count_cfg;
      for (int i = 0; i < lim; i++) begin
         ofs_w = tsrl_pkg::TIME_W'(ofs_tab[i]);
         abs_t = ofs_w + tsrl_pkg::TIME_W'(epoch_cfg);
         if (ofs_w < elapsed) begin
            r.current_on     = on_tab[i];
            r.current_resume = resume_tab[i];
            r.window_start   = abs_t;
            if (elapsed < ofs_w + tsrl_pkg::TIME_W'(window_cfg))
               r.in_window = 1'b1;
         end else if (on_tab[i]) begin
            if (!r.next_on_found) begin
               r.next_on_found = 1'b1;
               r.next_on_time  = abs_t;
            end
         end else if (!r.next_off_found) begin
            r.next_off_found = 1'b1;
            r.next_off_time  = abs_t;
         end
      end
      return r;
   endfunction

   task automatic apply_word(sched_word_type w);
      if (w.op == tsrl_pkg::OP_WRITE) begin
         ofs_tab[w.idx]    = w.ofs;
         on_tab[w.idx]     = w.turns_on;
         resume_tab[w.idx] = w.may_resume;
      end else begin
         pending_regions.push_back(lookup_region(w.now));
      end
   endtask

   function automatic void check_field(string name, logic [tsrl_pkg::TIME_W-1:0] want,
                                       logic [tsrl_pkg::TIME_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // driver: holds a word until it is taken, may idle between words
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            apply_word(offered);
         if (!req_tvalid || req_tready) begin
            if (stim_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = stim_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= offered.op;
               req_tdata  <= {offered.now, offered.may_resume, offered.turns_on,
                              offered.ofs, offered.idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_region = rsp_tdata;
            if (pending_regions.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %0h", $time, rsp_tdata);
               errors++;
            end else begin
               want_region = pending_regions.pop_front();
               check_field("current_on", want_region.current_on, got_region.current_on);
               check_field("current_resume", want_region.current_resume,
                           got_region.current_resume);
               check_field("in_window", want_region.in_window, got_region.in_window);
               check_field("window_start", want_region.window_start,
                           got_region.window_start);
               check_field("next_on_found", want_region.next_on_found,
                           got_region.next_on_found);
               check_field("next_on_time", want_region.next_on_time,
                           got_region.next_on_time);
               check_field("next_off_found", want_region.next_off_found,
                           got_region.next_off_found);
               check_field("next_off_time", want_region.next_off_time,
                           got_region.next_off_time);
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_register(logic [tsrl_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [tsrl_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tsrl_pkg::CSR_EPOCH:  epoch_cfg = value;
         tsrl_pkg::CSR_COUNT:  count_cfg = value[tsrl_pkg::CNT_REG_W-1:0];
         tsrl_pkg::CSR_WINDOW: window_cfg = value[tsrl_pkg::WINDOW_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // unused upper bits of count and window carry random values
   task automatic configure(logic [tsrl_pkg::EPOCH_W-1:0] epoch,
                            logic [tsrl_pkg::CNT_REG_W-1:0] count,
                            logic [tsrl_pkg::WINDOW_W-1:0] window);
      logic [tsrl_pkg::CSR_DATA_W-1:0] v;
      write_register(tsrl_pkg::CSR_EPOCH, epoch);
      v = rand40();
      v[tsrl_pkg::CNT_REG_W-1:0] = count;
      write_register(tsrl_pkg::CSR_COUNT, v);
      v = rand40();
      v[tsrl_pkg::WINDOW_W-1:0] = window;
      write_register(tsrl_pkg::CSR_WINDOW, v);
   endtask

   task automatic push_write(logic [tsrl_pkg::ADDR_W-1:0] idx,
                             logic [tsrl_pkg::OFFSET_W-1:0] ofs,
                             logic turns_on, logic may_resume);
      sched_word_type w;
      w.op         = tsrl_pkg::OP_WRITE;
      w.idx        = idx;
      w.ofs        = ofs;
      w.turns_on   = turns_on;
      w.may_resume = may_resume;
      w.now        = rand40();
      stim_words.push_back(w);
      gen_written[idx] = 1'b1;
   endtask

   task automatic push_query(logic [tsrl_pkg::EPOCH_W-1:0] now);
      sched_word_type w;
      w.op         = tsrl_pkg::OP_QUERY;
      w.idx        = tsrl_pkg::ADDR_W'($urandom);
      w.ofs        = $urandom;
      w.turns_on   = rand_bit();
      w.may_resume = rand_bit();
      w.now        = now;
      stim_words.push_back(w);
   endtask

   function automatic logic [tsrl_pkg::OFFSET_W-1:0] rand_offset();
      case ($urandom_range(9))
         0, 1:    return $urandom;
         2:       return 32'hFFFF_FFFF - $urandom_range(300);
         default: return $urandom_range(300);
      endcase
   endfunction

   // mostly times near the entries, some before the epoch or anywhere
   function automatic logic [tsrl_pkg::EPOCH_W-1:0] rand_now();
      case ($urandom_range(9))
         0:       return rand40();
         1:       return epoch_cfg - $urandom_range(1, 50);
         2:       return epoch_cfg + 40'h1_0000_0000 - $urandom_range(300);
         default: return epoch_cfg + $urandom_range(400);
      endcase
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (stim_words.size() != 0 || req_tvalid || pending_regions.size() != 0);
   endtask

   initial begin
      int                             lim;
      logic [tsrl_pkg::CNT_REG_W-1:0] count;
      logic [tsrl_pkg::EPOCH_W-1:0]   epoch;
      logic [tsrl_pkg::WINDOW_W-1:0]  window;
      logic [tsrl_pkg::OFFSET_W-1:0]  running;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: a small table around epoch 1000 with a 10 s window
      configure(40'd1000, 7'd4, 16'd10);
      write_register(CSR_SPARE, rand40());
      @(negedge clock);
      push_write(6'd0, 32'd0, 1'b1, 1'b0);
      push_write(6'd1, 32'd50, 1'b0, 1'b1);
      push_write(6'd2, 32'd100, 1'b1, 1'b1);
      push_write(6'd3, 32'hFFFF_FFFF, 1'b0, 1'b0);
      push_write(6'd63, $urandom, 1'b1, 1'b1);
      push_query(40'd0);
      push_query(40'd1000);
      push_query(40'd1001);
      push_query(40'd1050);
      push_query(40'd1051);
      push_query(40'd1059);
      push_query(40'd1060);
      push_query(40'd1101);
      push_query(40'd1000 + 40'h1_0000_0000);
      push_query(40'hFF_FFFF_FFFF);

      for (int p = 0; p < 15; p++) begin
         wait_drained();
         // a write may still be in flight after the last result
         repeat (70) @(posedge clock);
         case (p)
            3:       count = 7'd64;
            8:       count = 7'd127;
            11:      count = 7'd0;
            default: count = tsrl_pkg::CNT_REG_W'($urandom_range(1, 16));
         endcase
         case (p)
            4:       epoch = '0;
            6:       epoch = '1;
            default: epoch = $urandom_range(1) ? rand40()
                                               : tsrl_pkg::EPOCH_W'($urandom_range(5000));
         endcase
         case (p)
            5:       window = 16'hFFFF;
            7:       window = '0;
            default: window = $urandom_range(3) == 0
                                 ? tsrl_pkg::WINDOW_W'($urandom)
                                 : tsrl_pkg::WINDOW_W'($urandom_range(150));
         endcase
         configure(epoch, count, window);
         @(negedge clock);
         if (p < 5) begin
            send_idle_pct = 23;
            recv_idle_pct = 77;
         end else if (p < 10) begin
            send_idle_pct = 77;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // every scanned slot is written before the first query of the phase
         lim = (count > tsrl_pkg::MAX_ENTRIES) ? tsrl_pkg::MAX_ENTRIES : count;
         running = $urandom_range(20);
         for (int i = 0; i < lim; i++) begin
            if (p % 2 == 0) begin
               // ascending offsets, as a real schedule has them
               running += $urandom_range(40);
               push_write(tsrl_pkg::ADDR_W'(i), running, rand_bit(), rand_bit());
            end else if (!gen_written[i] || $urandom_range(3) == 0) begin
               push_write(tsrl_pkg::ADDR_W'(i), rand_offset(), rand_bit(), rand_bit());
            end
         end
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(99) < 30)
               push_write(tsrl_pkg::ADDR_W'($urandom_range(tsrl_pkg::MAX_ENTRIES - 1)),
                          rand_offset(), rand_bit(), rand_bit());
            else
               push_query(rand_now());
         end

         // long receiver stall, counted in its own process, so the block
         // backs up into its input while the sender keeps offering
         if (p == 2) begin
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (400) @(negedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
         end
      end

      wait_drained();
      repeat (80) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
